>>> hdl/clook_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes for the C-LOOK request scheduler.
// No dependencies; every other file of the block imports this package.
package clook_pkg;

  localparam int MAX_REQUESTS   = 64;
  localparam int TRACK_BITS     = 16;
  localparam int IDX_BITS       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_BITS       = $clog2(MAX_REQUESTS + 1);
  localparam int DIST_BITS      = TRACK_BITS + 1;
  localparam int MEM_ADDR_BITS  = IDX_BITS + 1;          // bank bit + entry index
  localparam int MEM_DEPTH      = 2 * (2 ** IDX_BITS);
  localparam int IN_TDATA_BITS  = ((TRACK_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((TRACK_BITS + DIST_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = TRACK_BITS;

  // register indexes on the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWEEP_RIGHT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEAD_START  = 1'd1;

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // one loaded batch handed from the front to the back
  typedef struct packed {
    logic   bank;
    cnt_t   count;
    track_t low;
    track_t high;
    track_t head;
    logic   right;
  } batch_t;

  // request store write port driven by the front
  typedef struct packed {
    logic                     en;
    logic [MEM_ADDR_BITS-1:0] addr;
    track_t                   data;
  } mem_wr_t;

  // batch queue status
  typedef struct packed {
    logic       empty;
    logic [1:0] level;
  } q_status_t;

endpackage

>>> hdl/clook_front.sv
`timescale 1ns / 1ps
// Front end: config registers, request loading into the current bank,
// lowest/highest tracking, and batch hand-off. Depends on clook_pkg.
module clook_front import clook_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  input  logic                      s_tlast,
  input  logic                      load_ok,
  output mem_wr_t                   mem_wr,
  output logic                      push,
  output batch_t                    push_batch
);

  logic   sweep_right;
  track_t head_start;
  cnt_t   count;
  track_t low;
  track_t high;
  logic   bank;

  logic   accept;
  logic   room;
  track_t track;
  cnt_t   count_next;
  track_t low_next;
  track_t high_next;

  assign s_tready = load_ok;
  assign accept   = s_tvalid && load_ok;
  assign track    = s_tdata[TRACK_BITS-1:0];
  assign room     = count < CNT_BITS'(MAX_REQUESTS);

  // requests past a full store are dropped
  always_comb begin
    count_next = count;
    low_next   = low;
    high_next  = high;
    if (room) begin
      count_next = count + CNT_BITS'(1);
      if (track < low) low_next = track;
      if (track > high) high_next = track;
    end
  end

  assign mem_wr.en   = accept && room;
  assign mem_wr.addr = {bank, count[IDX_BITS-1:0]};
  assign mem_wr.data = track;

  assign push             = accept && s_tlast;
  assign push_batch.bank  = bank;
  assign push_batch.count = count_next;
  assign push_batch.low   = low_next;
  assign push_batch.high  = high_next;
  assign push_batch.head  = head_start;
  assign push_batch.right = sweep_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_right <= 1'b0;
      head_start  <= '0;
      count       <= '0;
      low         <= '1;
      high        <= '0;
      bank        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_SWEEP_RIGHT: sweep_right <= cfg_wdata[0];
          REG_HEAD_START:  head_start  <= cfg_wdata[TRACK_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (s_tlast) begin
          count <= '0;
          low   <= '1;
          high  <= '0;
          bank  <= ~bank;
        end else begin
          count <= count_next;
          low   <= low_next;
          high  <= high_next;
        end
      end
    end
  end

endmodule

>>> hdl/clook_queue.sv
`timescale 1ns / 1ps
// Two-entry batch descriptor queue between front and back.
// Depends on clook_pkg.
module clook_queue import clook_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  batch_t    push_batch,
  input  logic      pop,
  output batch_t    head_batch,
  output q_status_t status
);

  batch_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] level;

  logic do_push;
  logic do_pop;

  assign do_push = push && (level != 2'd2);
  assign do_pop  = pop && (level != 2'd0);

  assign head_batch   = slots[rptr];
  assign status.empty = (level == 2'd0);
  assign status.level = level;

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_batch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      case ({do_push, do_pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

>>> hdl/clook_back.sv
`timescale 1ns / 1ps
// Back end: two-bank request store and the selection engine that emits
// each batch in C-LOOK order with the head travel. Depends on clook_pkg.
module clook_back import clook_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  mem_wr_t                   mem_wr,
  input  q_status_t                 q_status,
  input  batch_t                    q_head,
  output logic                      pop,
  output logic                      busy,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  output logic                      m_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t               state;
  batch_t               job;
  logic [MAX_REQUESTS-1:0] served;
  cnt_t                 emitted;
  cnt_t                 issue_idx;
  logic                 rd_pend;
  logic [IDX_BITS-1:0]  rd_idx;
  track_t               rd_data;
  logic                 best_valid;
  logic [TRACK_BITS:0]  best_key;
  logic [IDX_BITS-1:0]  best_idx;
  track_t               best_track;
  logic                 far_any;
  track_t               far_last;
  track_t               near_d;

  track_t mem [MEM_DEPTH];

  logic                 rd_en;
  logic                 rd_far;
  logic [TRACK_BITS:0]  rd_key;
  logic                 take;
  logic                 best_far;
  logic                 last;
  logic                 out_free;
  logic                 emit_now;
  logic                 far_any_now;
  track_t               far_last_now;
  track_t               far_d;
  logic [DIST_BITS-1:0] total;
  logic [DIST_BITS-1:0] dist_out;
  track_t               near_init;

  // request store: written by the front, read by the scan
  always_ff @(posedge clk) begin
    if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[{job.bank, issue_idx[IDX_BITS-1:0]}];
  end

  assign rd_en = (state == ST_SCAN) && (issue_idx < job.count);

  // order key: near side first, then nearest-in-sweep-direction first
  assign rd_far = job.right ? (rd_data < job.head) : (rd_data > job.head);
  assign rd_key = {rd_far, job.right ? rd_data : ~rd_data};
  // strict compare keeps the earliest-loaded copy on ties
  assign take   = rd_pend && !served[rd_idx] && (!best_valid || rd_key < best_key);

  assign best_far = best_key[TRACK_BITS];
  assign last     = (emitted + CNT_BITS'(1)) == job.count;
  assign out_free = !m_tvalid || m_tready;
  assign emit_now = (state == ST_EMIT) && out_free;

  assign far_any_now  = far_any || best_far;
  assign far_last_now = best_far ? best_track : far_last;

  always_comb begin
    far_d = '0;
    if (far_any_now) begin
      far_d = job.right ? (far_last_now - job.low) : (job.high - far_last_now);
    end
  end

  assign total    = {1'b0, near_d} + {1'b0, far_d};
  assign dist_out = last ? total : '0;

  always_comb begin
    near_init = '0;
    if (q_head.right) begin
      if (q_head.high >= q_head.head) near_init = q_head.high - q_head.head;
    end else begin
      if (q_head.low <= q_head.head) near_init = q_head.head - q_head.low;
    end
  end

  assign pop  = (state == ST_IDLE) && !q_status.empty;
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      rd_idx  <= issue_idx[IDX_BITS-1:0];
      if (m_tvalid && m_tready && !emit_now) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            job        <= q_head;
            near_d     <= near_init;
            served     <= '0;
            emitted    <= '0;
            issue_idx  <= '0;
            best_valid <= 1'b0;
            far_any    <= 1'b0;
            far_last   <= '0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) issue_idx <= issue_idx + CNT_BITS'(1);
          if (take) begin
            best_valid <= 1'b1;
            best_key   <= rd_key;
            best_idx   <= rd_idx;
            best_track <= rd_data;
          end
          if (!rd_en && !rd_pend) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid         <= 1'b1;
            m_tdata          <= OUT_TDATA_BITS'({dist_out, best_track});
            m_tlast          <= last;
            served[best_idx] <= 1'b1;
            emitted          <= emitted + CNT_BITS'(1);
            far_any          <= far_any_now;
            far_last         <= far_last_now;
            issue_idx        <= '0;
            best_valid       <= 1'b0;
            state            <= last ? ST_IDLE : ST_SCAN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/clook_disk_request_scheduler_top.sv
`timescale 1ns / 1ps
// C-LOOK disk request scheduler, top level. Loads track requests one per
// cycle while s_tready is high; the request flagged with tlast closes the
// batch and the block emits every stored request in C-LOOK order. After the
// batch closes, each served request takes one full pass over the store
// through its single read port, plus the emit step; up to 64 requests are
// kept, more are dropped.
// The store has two banks: the next batch loads while the previous one is
// drained, and s_tready drops only while two closed batches are pending.
// The last request of a batch carries tlast and the total head travel,
// near sweep plus far sweep, not counting the jump across; an empty side
// adds nothing. Config writes (index 0: sweep_right, index 1: head_start)
// apply to batches closed afterwards. Depends on clook_pkg, clook_front,
// clook_queue and clook_back.
module clook_disk_request_scheduler_top import clook_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // config write port
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  // request in
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [15:0] track
  input  logic                      s_tlast,   // final_request
  // served request out
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [15:0] served_track, [32:16] total_distance
  output logic                      m_tlast    // end_of_order
);

  mem_wr_t   mem_wr;
  logic      push;
  batch_t    push_batch;
  batch_t    q_head;
  q_status_t q_status;
  logic      pop;
  logic      back_busy;
  logic      load_ok;

  // each closed batch holds a bank until drained; two banks in total
  assign load_ok = (q_status.level == 2'd0) ||
                   ((q_status.level == 2'd1) && !back_busy);

  clook_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .load_ok    (load_ok),
    .mem_wr     (mem_wr),
    .push       (push),
    .push_batch (push_batch)
  );

  clook_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_batch (push_batch),
    .pop        (pop),
    .head_batch (q_head),
    .status     (q_status)
  );

  clook_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mem_wr   (mem_wr),
    .q_status (q_status),
    .q_head   (q_head),
    .pop      (pop),
    .busy     (back_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> hdl/clook_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the C-LOOK scheduler top, bound to it below.
// Depends on clook_pkg and clook_disk_request_scheduler_top.
module clook_port_checks import clook_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      s_tlast,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_TDATA_BITS-1:0] m_tdata,
  input logic                      m_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // travel is reported only on the last request of a batch
  a_dist_last_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[TRACK_BITS+DIST_BITS-1:TRACK_BITS] == '0)
    else $error("distance on a non-final result");

  // reset empties the output and frees both banks
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // a request that does not close a batch never stalls the next one
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> s_tready)
    else $error("input stalled in mid-batch");

endmodule

bind clook_disk_request_scheduler_top clook_port_checks u_clook_port_checks (.*);
